// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clk edge, ignored while rst is high.
`define PCAW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clk edge, reset included.
`define PCAW_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/pcaw_pkg.sv
// Package with constants, register indexes and a saturation helper for the PI controller.
package pcaw_pkg;

  // Default data width and gain fraction bits
  localparam int DATA_WIDTH     = 16;
  localparam int GAIN_FRAC_BITS = 12;

  // Fixed widths
  localparam int GAIN_BITS      = 16;
  localparam int INTEG_BITS     = 32;
  localparam int CFG_INDEX_BITS = 3;

  // Reset values of the output limits
  localparam longint UPPER_RESET = 32767;
  localparam longint LOWER_RESET = -32768;

  // Saturation bounds of the integrator
  localparam logic signed [63:0] INTEG_MAX = 64'sd2147483647;
  localparam logic signed [63:0] INTEG_MIN = -64'sd2147483648;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_P_GAIN      = 3'd0,
    REG_I_GAIN      = 3'd1,
    REG_I_GAIN_PREV = 3'd2,
    REG_UPPER_LIMIT = 3'd3,
    REG_LOWER_LIMIT = 3'd4
  } cfg_reg_t;

  // Saturate a wide signed value to the integrator range
  function automatic logic signed [INTEG_BITS-1:0] sat32(input logic signed [63:0] v);
    logic signed [INTEG_BITS-1:0] r;
    if (v > INTEG_MAX) begin
      r = INTEG_MAX[INTEG_BITS-1:0];
    end else if (v < INTEG_MIN) begin
      r = INTEG_MIN[INTEG_BITS-1:0];
    end else begin
      r = v[INTEG_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/pi_controller_clamp_antiwindup.sv
// Top level of the PI controller with clamping anti-windup.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------
//   in       | in_valid, in_stall  | error
//   out      | out_valid, out_stall| drive, limit_hit
//   cfg      | cfg_write           | cfg_index, cfg_data
//
// One item per cycle while the output does not stall: an item is held in the
// input register, then the three gain products, integral sum and clamp run in
// one pass into the result register.
// The integrator and previous error update as an item moves into the result
// register; that single feedback loop sets the clock period.
// Synchronous rst empties both registers and reloads gains and limits.
// A stalled output holds its result; in_stall rises only when the input
// register is full and cannot move on.
`include "assert_macros.svh"

module pi_controller_clamp_antiwindup #(
  parameter int DATA_WIDTH     = pcaw_pkg::DATA_WIDTH,
  parameter int GAIN_FRAC_BITS = pcaw_pkg::GAIN_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration write port
  input  logic                                   cfg_write,
  input  logic [pcaw_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [((DATA_WIDTH > pcaw_pkg::GAIN_BITS) ?
                 DATA_WIDTH : pcaw_pkg::GAIN_BITS)-1:0] cfg_data,
  // Input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [DATA_WIDTH-1:0]           error,
  // Output channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [DATA_WIDTH-1:0]           drive,
  output logic                                   limit_hit
);

  localparam int GB = pcaw_pkg::GAIN_BITS;
  localparam int PW = GB + DATA_WIDTH;
  localparam int IB = pcaw_pkg::INTEG_BITS;

  localparam longint UPPER_RST = (DATA_WIDTH >= 16) ? pcaw_pkg::UPPER_RESET :
                                 (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam longint LOWER_RST = (DATA_WIDTH >= 16) ? pcaw_pkg::LOWER_RESET :
                                 -(64'sd1 <<< (DATA_WIDTH - 1));

  // Configuration registers
  logic signed [GB-1:0]         p_gain;
  logic signed [GB-1:0]         i_gain;
  logic signed [GB-1:0]         i_gain_prev;
  logic signed [DATA_WIDTH-1:0] upper_limit;
  logic signed [DATA_WIDTH-1:0] lower_limit;

  // Controller state
  logic signed [IB-1:0]         integrator;
  logic signed [DATA_WIDTH-1:0] prev_error;

  // Input register
  logic                         a_valid;
  logic signed [DATA_WIDTH-1:0] a_error;

  // Datapath
  logic signed [PW-1:0]         p_term;
  logic signed [PW-1:0]         i_term;
  logic signed [PW-1:0]         q_term;
  logic signed [DATA_WIDTH-1:0] drive_next;
  logic                         limit_hit_next;
  logic signed [IB-1:0]         integrator_next;
  logic                         advance;

  // Write configuration registers; unknown indexes do nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain      <= '0;
      i_gain      <= '0;
      i_gain_prev <= '0;
      upper_limit <= DATA_WIDTH'(UPPER_RST);
      lower_limit <= DATA_WIDTH'(LOWER_RST);
    end else if (cfg_write) begin
      case (pcaw_pkg::cfg_reg_t'(cfg_index))
        pcaw_pkg::REG_P_GAIN:      p_gain      <= cfg_data[GB-1:0];
        pcaw_pkg::REG_I_GAIN:      i_gain      <= cfg_data[GB-1:0];
        pcaw_pkg::REG_I_GAIN_PREV: i_gain_prev <= cfg_data[GB-1:0];
        pcaw_pkg::REG_UPPER_LIMIT: upper_limit <= cfg_data[DATA_WIDTH-1:0];
        pcaw_pkg::REG_LOWER_LIMIT: lower_limit <= cfg_data[DATA_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Move an item forward when the result register is free or being drained
  assign advance  = a_valid && (!out_valid || !out_stall);
  assign in_stall = a_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!in_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_error <= error;
    end
  end

  // Gain products
  pcaw_scale #(.DATA_WIDTH(DATA_WIDTH), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_scale_p (
    .gain   (p_gain),
    .sample (a_error),
    .scaled (p_term)
  );

  pcaw_scale #(.DATA_WIDTH(DATA_WIDTH), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_scale_i (
    .gain   (i_gain),
    .sample (a_error),
    .scaled (i_term)
  );

  pcaw_scale #(.DATA_WIDTH(DATA_WIDTH), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_scale_q (
    .gain   (i_gain_prev),
    .sample (prev_error),
    .scaled (q_term)
  );

  // Integral sum and clamp
  pcaw_law #(.DATA_WIDTH(DATA_WIDTH)) u_law (
    .integrator      (integrator),
    .p_term          (p_term),
    .i_term          (i_term),
    .q_term          (q_term),
    .upper_limit     (upper_limit),
    .lower_limit     (lower_limit),
    .drive           (drive_next),
    .limit_hit       (limit_hit_next),
    .integrator_next (integrator_next)
  );

  // Update controller state as the item completes
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
      prev_error <= '0;
    end else if (advance) begin
      integrator <= integrator_next;
      prev_error <= a_error;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive     <= drive_next;
      limit_hit <= limit_hit_next;
    end
  end

  // Checks on the controller's own logic
  `PCAW_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> a_valid, "stall without held item")
  `PCAW_ASSERT(a_result_from_item, $rose(out_valid) |-> $past(a_valid), "result without item")
  `PCAW_ASSERT(a_prev_error_tracks, advance |=> prev_error == $past(a_error), "prev error lost")
  `PCAW_ASSERT(a_clamp_value, out_valid && limit_hit |-> drive == upper_limit || drive == lower_limit, "clamped drive off limit")
  `PCAW_ASSERT(a_free_in_range, out_valid && !limit_hit |-> drive <= upper_limit && drive >= lower_limit, "drive outside limits")

endmodule

// File: rtl/core/pcaw_scale.sv
// Gain times sample in Q4.12, shifted right arithmetically by the fraction bits.
module pcaw_scale #(
  parameter int DATA_WIDTH     = pcaw_pkg::DATA_WIDTH,
  parameter int GAIN_FRAC_BITS = pcaw_pkg::GAIN_FRAC_BITS
) (
  input  logic signed [pcaw_pkg::GAIN_BITS-1:0]            gain,
  input  logic signed [DATA_WIDTH-1:0]                     sample,
  output logic signed [pcaw_pkg::GAIN_BITS+DATA_WIDTH-1:0] scaled
);

  localparam int PW = pcaw_pkg::GAIN_BITS + DATA_WIDTH;

  logic signed [PW-1:0] prod;

  // Full product fits PW bits, so the shifted term never needs clamping
  assign prod   = PW'(gain) * PW'(sample);
  assign scaled = prod >>> GAIN_FRAC_BITS;

endmodule

// File: rtl/core/pcaw_law.sv
// Integral sum, output clamp and integrator reload for one error item.
module pcaw_law #(
  parameter int DATA_WIDTH = pcaw_pkg::DATA_WIDTH
) (
  input  logic signed [pcaw_pkg::INTEG_BITS-1:0]           integrator,
  input  logic signed [pcaw_pkg::GAIN_BITS+DATA_WIDTH-1:0] p_term,
  input  logic signed [pcaw_pkg::GAIN_BITS+DATA_WIDTH-1:0] i_term,
  input  logic signed [pcaw_pkg::GAIN_BITS+DATA_WIDTH-1:0] q_term,
  input  logic signed [DATA_WIDTH-1:0]                     upper_limit,
  input  logic signed [DATA_WIDTH-1:0]                     lower_limit,
  output logic signed [DATA_WIDTH-1:0]                     drive,
  output logic                                             limit_hit,
  output logic signed [pcaw_pkg::INTEG_BITS-1:0]           integrator_next
);

  localparam int PW   = pcaw_pkg::GAIN_BITS + DATA_WIDTH;
  localparam int BW   = (PW > pcaw_pkg::INTEG_BITS) ? PW : pcaw_pkg::INTEG_BITS;
  localparam int SUMW = BW + 2;
  localparam int UW   = BW + 1;

  logic signed [SUMW-1:0]                 sum;
  logic signed [pcaw_pkg::INTEG_BITS-1:0] i_sat;
  logic signed [UW-1:0]                   u;
  logic signed [UW-1:0]                   upper_ext;
  logic signed [UW-1:0]                   lower_ext;

  // Integrator plus both integral terms, saturated to 32 bits
  assign sum   = SUMW'(integrator) + SUMW'(i_term) + SUMW'(q_term);
  assign i_sat = pcaw_pkg::sat32(64'(sum));

  // Unclamped output
  assign u         = UW'(p_term) + UW'(i_sat);
  assign upper_ext = UW'(upper_limit);
  assign lower_ext = UW'(lower_limit);

  // Clamp: upper limit wins, reload integrator on a clamp
  always_comb begin
    drive           = u[DATA_WIDTH-1:0];
    limit_hit       = 1'b0;
    integrator_next = i_sat;
    if (u > upper_ext) begin
      drive           = upper_limit;
      limit_hit       = 1'b1;
      integrator_next = pcaw_pkg::sat32(64'(upper_ext - UW'(p_term)));
    end else if (u < lower_ext) begin
      drive           = lower_limit;
      limit_hit       = 1'b1;
      integrator_next = pcaw_pkg::sat32(64'(lower_ext - UW'(p_term)));
    end
  end

endmodule
